[rtl/day_hms_time_accumulator_assert.svh]
// Assertion macros for the day/hour/minute/second accumulator.
// Define ASSERT_OFF to compile the checks away.
`ifndef DAY_HMS_TIME_ACCUMULATOR_ASSERT_SVH
`define DAY_HMS_TIME_ACCUMULATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is active
`define DHMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// Next-cycle implication, disabled while reset is active
`define DHMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define DHMS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DHMS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/dhms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dhms_pkg;

  // Field widths
  localparam int OP_W       = 3;
  localparam int OPND_DAY_W = 16;
  localparam int OUT_DAY_W  = 16;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int TOTAL_W    = 33;
  localparam int STATUS_W   = 2;

  // Radix constants
  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SEC_MAX       = 59;
  localparam int MIN_MAX       = 59;
  localparam int HOUR_MAX      = 23;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 3'd0,
    OP_INC  = 3'd1,
    OP_DEC  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // Time-of-day part of a step result plus its control
  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    status_t           status;
    logic              wr_en;
  } step_res_t;

endpackage

`default_nettype wire

[rtl/dhms_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module dhms_step
  import dhms_pkg::*;
#(
  parameter int DAY_BITS = 16
) (
  input  logic [OP_W-1:0]       op,
  input  logic [OPND_DAY_W-1:0] opnd_days,
  input  logic [HOUR_W-1:0]     opnd_hours,
  input  logic [MIN_W-1:0]      opnd_minutes,
  input  logic [SEC_W-1:0]      opnd_seconds,
  input  logic [DAY_BITS-1:0]   cur_days,
  input  logic [HOUR_W-1:0]     cur_hours,
  input  logic [MIN_W-1:0]      cur_minutes,
  input  logic [SEC_W-1:0]      cur_seconds,
  output logic [DAY_BITS-1:0]   days_nxt,
  output step_res_t             res
);

  // Day arithmetic room: widest day field plus carry and sign
  localparam int SW = ((DAY_BITS > OPND_DAY_W) ? DAY_BITS : OPND_DAY_W) + 2;

  logic              is_arith;
  logic              is_sub;
  logic [SW-1:0]     base_d, arg_d;
  logic [HOUR_W-1:0] base_h, arg_h;
  logic [MIN_W-1:0]  base_m, arg_m;
  logic [SEC_W-1:0]  base_s, arg_s;

  logic [6:0]    s_sum, s_add;
  logic [6:0]    m_sum, m_add;
  logic [5:0]    h_sum, h_add;
  logic [1:0]    c_s, c_m, c_h;
  logic [SW-1:0] d_sum;
  logic          ovf;

  logic [6:0]    s_dif, s_adj, s_sub;
  logic [7:0]    m_dif, m_adj, m_sub;
  logic [6:0]    h_dif, h_adj, h_sub;
  logic [1:0]    b_s, b_m, b_h;
  logic [SW-1:0] d_dif;
  logic          neg;

  // Decode the operation into base, argument and direction
  always_comb begin
    is_arith = 1'b0;
    is_sub   = 1'b0;
    base_d   = SW'(cur_days);
    base_h   = cur_hours;
    base_m   = cur_minutes;
    base_s   = cur_seconds;
    arg_d    = '0;
    arg_h    = '0;
    arg_m    = '0;
    arg_s    = '0;
    unique case (op)
      OP_LOAD: begin
        is_arith = 1'b1;
        base_d   = '0;
        base_h   = '0;
        base_m   = '0;
        base_s   = '0;
        arg_d    = SW'(opnd_days);
        arg_h    = opnd_hours;
        arg_m    = opnd_minutes;
        arg_s    = opnd_seconds;
      end
      OP_INC: begin
        is_arith = 1'b1;
        arg_s    = SEC_W'(1);
      end
      OP_DEC: begin
        is_arith = 1'b1;
        is_sub   = 1'b1;
        arg_s    = SEC_W'(1);
      end
      OP_ADD: begin
        is_arith = 1'b1;
        arg_d    = SW'(opnd_days);
        arg_h    = opnd_hours;
        arg_m    = opnd_minutes;
        arg_s    = opnd_seconds;
      end
      OP_SUB: begin
        is_arith = 1'b1;
        is_sub   = 1'b1;
        arg_d    = SW'(opnd_days);
        arg_h    = opnd_hours;
        arg_m    = opnd_minutes;
        arg_s    = opnd_seconds;
      end
      default: begin
        is_arith = 1'b0;
      end
    endcase
  end

  // Add with mixed-radix carry; a denormal operand can carry by two
  always_comb begin
    s_sum = {1'b0, base_s} + {1'b0, arg_s};
    if (s_sum >= 7'(2 * SECS_PER_MIN)) begin
      c_s   = 2'd2;
      s_add = s_sum - 7'(2 * SECS_PER_MIN);
    end else if (s_sum >= 7'(SECS_PER_MIN)) begin
      c_s   = 2'd1;
      s_add = s_sum - 7'(SECS_PER_MIN);
    end else begin
      c_s   = 2'd0;
      s_add = s_sum;
    end

    m_sum = {1'b0, base_m} + {1'b0, arg_m} + 7'(c_s);
    if (m_sum >= 7'(2 * MINS_PER_HOUR)) begin
      c_m   = 2'd2;
      m_add = m_sum - 7'(2 * MINS_PER_HOUR);
    end else if (m_sum >= 7'(MINS_PER_HOUR)) begin
      c_m   = 2'd1;
      m_add = m_sum - 7'(MINS_PER_HOUR);
    end else begin
      c_m   = 2'd0;
      m_add = m_sum;
    end

    h_sum = {1'b0, base_h} + {1'b0, arg_h} + 6'(c_m);
    if (h_sum >= 6'(2 * HOURS_PER_DAY)) begin
      c_h   = 2'd2;
      h_add = h_sum - 6'(2 * HOURS_PER_DAY);
    end else if (h_sum >= 6'(HOURS_PER_DAY)) begin
      c_h   = 2'd1;
      h_add = h_sum - 6'(HOURS_PER_DAY);
    end else begin
      c_h   = 2'd0;
      h_add = h_sum;
    end

    d_sum = base_d + arg_d + SW'(c_h);
    ovf   = (d_sum >> DAY_BITS) != '0;
  end

  // Subtract with mixed-radix borrow; negative day count means underflow
  always_comb begin
    s_dif = {1'b0, base_s} - {1'b0, arg_s};
    s_adj = s_dif + 7'(SECS_PER_MIN);
    if (!s_dif[6]) begin
      b_s   = 2'd0;
      s_sub = s_dif;
    end else if (!s_adj[6]) begin
      b_s   = 2'd1;
      s_sub = s_adj;
    end else begin
      b_s   = 2'd2;
      s_sub = s_dif + 7'(2 * SECS_PER_MIN);
    end

    m_dif = {2'b00, base_m} - {2'b00, arg_m} - 8'(b_s);
    m_adj = m_dif + 8'(MINS_PER_HOUR);
    if (!m_dif[7]) begin
      b_m   = 2'd0;
      m_sub = m_dif;
    end else if (!m_adj[7]) begin
      b_m   = 2'd1;
      m_sub = m_adj;
    end else begin
      b_m   = 2'd2;
      m_sub = m_dif + 8'(2 * MINS_PER_HOUR);
    end

    h_dif = {2'b00, base_h} - {2'b00, arg_h} - 7'(b_m);
    h_adj = h_dif + 7'(HOURS_PER_DAY);
    if (!h_dif[6]) begin
      b_h   = 2'd0;
      h_sub = h_dif;
    end else if (!h_adj[6]) begin
      b_h   = 2'd1;
      h_sub = h_adj;
    end else begin
      b_h   = 2'd2;
      h_sub = h_dif + 7'(2 * HOURS_PER_DAY);
    end

    d_dif = base_d - arg_d - SW'(b_h);
    neg   = d_dif[SW-1];
  end

  // Select the direction and grade the result
  always_comb begin
    if (is_sub) begin
      days_nxt    = d_dif[DAY_BITS-1:0];
      res.hours   = h_sub[HOUR_W-1:0];
      res.minutes = m_sub[MIN_W-1:0];
      res.seconds = s_sub[SEC_W-1:0];
    end else begin
      days_nxt    = d_sum[DAY_BITS-1:0];
      res.hours   = h_add[HOUR_W-1:0];
      res.minutes = m_add[MIN_W-1:0];
      res.seconds = s_add[SEC_W-1:0];
    end
    if (!is_arith) begin
      res.status = ST_OK;
    end else if (is_sub && neg) begin
      res.status = ST_UNDER;
    end else if (!is_sub && ovf) begin
      res.status = ST_OVER;
    end else begin
      res.status = ST_OK;
    end
    res.wr_en = is_arith && (res.status == ST_OK);
  end

endmodule

`default_nettype wire

[rtl/dhms_total.sv]
`timescale 1ns / 1ps
`default_nettype none

module dhms_total
  import dhms_pkg::*;
#(
  parameter int DAY_BITS = 16
) (
  input  logic [DAY_BITS-1:0] days,
  input  logic [HOUR_W-1:0]   hours,
  input  logic [MIN_W-1:0]    minutes,
  input  logic [SEC_W-1:0]    seconds,
  output logic [TOTAL_W-1:0]  total
);

  logic [TOTAL_W-1:0] day_secs;
  logic [TOTAL_W-1:0] tod_secs;

  // Scale days by a constant; keep the low bits only
  assign day_secs = TOTAL_W'(days) * TOTAL_W'(SECS_PER_DAY);

  // Seconds within the day
  assign tod_secs = TOTAL_W'(hours) * TOTAL_W'(SECS_PER_HOUR)
                  + TOTAL_W'(minutes) * TOTAL_W'(SECS_PER_MIN)
                  + TOTAL_W'(seconds);

  assign total = day_secs + tod_secs;

endmodule

`default_nettype wire

[rtl/day_hms_time_accumulator.sv]
// Day/hour/minute/second accumulator. Holds one normalized time (day count of
// DAY_BITS bits, hours 0-23, minutes 0-59, seconds 0-59, all zero after reset)
// and applies one operation per input transaction: load the operand, step one
// second up or down, add the operand, or subtract it. Operand hours, minutes
// and seconds above their normal range are carried up before use. A result
// below zero reports underflow and a day count beyond range reports overflow;
// either leaves the stored time untouched, as do unused op codes. Each input
// transaction yields exactly one output transaction with the stored time, its
// total in seconds (low 33 bits) and the status. Throughput is one transaction
// per cycle while out_tready stays high. The input register loads on the
// accepting edge, then the state update, then the total-seconds register,
// which drives out_tvalid. The stored time feeds back into the state-update
// stage each cycle, which is what sets the one-cycle issue rate. Ready
// propagates combinationally from out_tready to in_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "day_hms_time_accumulator_assert.svh"

module day_hms_time_accumulator
  import dhms_pkg::*;
#(
  parameter int DAY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // in_days[15:0], in_hours[20:16], in_minutes[26:21],
                                  // in_seconds[32:27], zero fill [39:33]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_days[15:0], out_hours[20:16], out_minutes[26:21],
                                  // out_seconds[32:27], total_seconds[65:33], zero [71:66]
  output logic [1:0]  out_tuser   // status[1:0]
);

  // Input stage
  logic                  s1_vld_r;
  logic [OP_W-1:0]       s1_op_r;
  logic [OPND_DAY_W-1:0] s1_days_r;
  logic [HOUR_W-1:0]     s1_hours_r;
  logic [MIN_W-1:0]      s1_min_r;
  logic [SEC_W-1:0]      s1_sec_r;

  // Stored time; also the time fields of the state-update stage
  logic                  s2_vld_r;
  status_t               s2_status_r;
  logic [DAY_BITS-1:0]   day_r;
  logic [HOUR_W-1:0]     hour_r;
  logic [MIN_W-1:0]      min_r;
  logic [SEC_W-1:0]      sec_r;

  // Output stage
  logic                  s3_vld_r;
  logic [OUT_DAY_W-1:0]  o_days_r;
  logic [HOUR_W-1:0]     o_hours_r;
  logic [MIN_W-1:0]      o_min_r;
  logic [SEC_W-1:0]      o_sec_r;
  logic [TOTAL_W-1:0]    o_total_r;
  status_t               o_status_r;

  logic                  s1_adv, s2_adv, s3_adv;
  logic [DAY_BITS-1:0]   day_nxt;
  step_res_t             step_res;
  logic [TOTAL_W-1:0]    total_nxt;

  // Advance each stage when it is empty or its successor moves
  assign s3_adv    = !s3_vld_r || out_tready;
  assign s2_adv    = !s2_vld_r || s3_adv;
  assign s1_adv    = !s1_vld_r || s2_adv;
  assign in_tready = s1_adv;

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r    <= in_tuser;
      s1_days_r  <= in_tdata[15:0];
      s1_hours_r <= in_tdata[20:16];
      s1_min_r   <= in_tdata[26:21];
      s1_sec_r   <= in_tdata[32:27];
    end
  end

  dhms_step #(
    .DAY_BITS (DAY_BITS)
  ) u_step (
    .op           (s1_op_r),
    .opnd_days    (s1_days_r),
    .opnd_hours   (s1_hours_r),
    .opnd_minutes (s1_min_r),
    .opnd_seconds (s1_sec_r),
    .cur_days     (day_r),
    .cur_hours    (hour_r),
    .cur_minutes  (min_r),
    .cur_seconds  (sec_r),
    .days_nxt     (day_nxt),
    .res          (step_res)
  );

  // Update the stored time and latch the status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r    <= 1'b0;
      s2_status_r <= ST_OK;
      day_r       <= '0;
      hour_r      <= '0;
      min_r       <= '0;
      sec_r       <= '0;
    end else if (s2_adv) begin
      s2_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        s2_status_r <= step_res.status;
        if (step_res.wr_en) begin
          day_r  <= day_nxt;
          hour_r <= step_res.hours;
          min_r  <= step_res.minutes;
          sec_r  <= step_res.seconds;
        end
      end
    end
  end

  dhms_total #(
    .DAY_BITS (DAY_BITS)
  ) u_total (
    .days    (day_r),
    .hours   (hour_r),
    .minutes (min_r),
    .seconds (sec_r),
    .total   (total_nxt)
  );

  // Register the result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && s3_adv) begin
      o_days_r   <= OUT_DAY_W'(day_r);
      o_hours_r  <= hour_r;
      o_min_r    <= min_r;
      o_sec_r    <= sec_r;
      o_total_r  <= total_nxt;
      o_status_r <= s2_status_r;
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata  = {6'b0, o_total_r, o_sec_r, o_min_r, o_hours_r, o_days_r};
  assign out_tuser  = o_status_r;

  // Delivered time is always normalized
  `DHMS_ASSERT_IMP(a_out_normalized, clk, rst_n, s3_vld_r,
    (o_hours_r <= HOUR_W'(HOUR_MAX)) && (o_min_r <= MIN_W'(MIN_MAX))
    && (o_sec_r <= SEC_W'(SEC_MAX)))
  // Stored time changes only when a transaction enters the update stage
  `DHMS_ASSERT_NXT(a_state_hold, clk, rst_n, !(s1_vld_r && s2_adv),
    $stable(day_r) && $stable(hour_r) && $stable(min_r) && $stable(sec_r))
  // A failed step leaves the stored time untouched
  `DHMS_ASSERT_NXT(a_err_no_write, clk, rst_n, s1_vld_r && s2_adv && (step_res.status != ST_OK),
    $stable(day_r) && $stable(hour_r) && $stable(min_r) && $stable(sec_r))
  // Input stalls only when every stage is occupied
  `DHMS_ASSERT_IMP(a_stall_full, clk, rst_n, !in_tready, s1_vld_r && s2_vld_r && s3_vld_r)

endmodule

`default_nettype wire

[tb/tb_day_hms_time_accumulator.sv]
`timescale 1ns / 1ps

module tb_day_hms_time_accumulator;
  import dhms_pkg::*;

  localparam int TB_DAY_BITS = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 375;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  // Op codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct {
    logic [OUT_DAY_W-1:0] days;
    logic [HOUR_W-1:0]    hours;
    logic [MIN_W-1:0]     minutes;
    logic [SEC_W-1:0]     seconds;
    logic [TOTAL_W-1:0]   total;
    status_t              status;
  } time_result_t;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [OPND_DAY_W-1:0] days;
    logic [HOUR_W-1:0]     hours;
    logic [MIN_W-1:0]      minutes;
    logic [SEC_W-1:0]      seconds;
    bit                    typed;
    time_result_t          want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // in_days[15:0], in_hours[20:16], in_minutes[26:21],
                           // in_seconds[32:27], zero fill [39:33]
  logic [2:0]  in_tuser;   // op[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // out_days[15:0], out_hours[20:16], out_minutes[26:21],
                           // out_seconds[32:27], total_seconds[65:33], zero [71:66]
  logic [1:0]  out_tuser;  // status[1:0]

  // Predicted stored time
  longint unsigned acc_days;
  longint unsigned acc_hours;
  longint unsigned acc_minutes;
  longint unsigned acc_seconds;

  time_result_t pending_times[$];
  stim_row_t    directed_rows[$];
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_seq;
  int           hold_seen;
  int           hold_left;
  logic         in_taken;

  day_hms_time_accumulator #(.DAY_BITS(TB_DAY_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned held_seconds();
    return ((acc_days * HOURS_PER_DAY + acc_hours) * MINS_PER_HOUR + acc_minutes)
           * SECS_PER_MIN + acc_seconds;
  endfunction

  // Split a second count back into fields; refuse it when the day count does not fit
  function automatic status_t commit_seconds(input longint unsigned secs);
    longint unsigned day_part;
    longint unsigned rest;
    day_part = secs / SECS_PER_DAY;
    rest     = secs % SECS_PER_DAY;
    if (day_part >= (64'd1 << TB_DAY_BITS)) return ST_OVER;
    acc_days    = day_part;
    acc_hours   = rest / SECS_PER_HOUR;
    rest        = rest % SECS_PER_HOUR;
    acc_minutes = rest / SECS_PER_MIN;
    acc_seconds = rest % SECS_PER_MIN;
    return ST_OK;
  endfunction

  function automatic time_result_t apply_time_op(input logic [OP_W-1:0] op,
                                                 input logic [OPND_DAY_W-1:0] d,
                                                 input logic [HOUR_W-1:0] h,
                                                 input logic [MIN_W-1:0] m,
                                                 input logic [SEC_W-1:0] s);
    longint unsigned cur;
    longint unsigned opnd;
    status_t         st;
    time_result_t    r;
    cur  = held_seconds();
    opnd = ((longint'(d) * HOURS_PER_DAY + h) * MINS_PER_HOUR + m) * SECS_PER_MIN + s;
    st   = ST_OK;
    case (op)
      OP_LOAD: st = commit_seconds(opnd);
      OP_INC:  st = commit_seconds(cur + 1);
      OP_DEC:  st = (cur == 0) ? ST_UNDER : commit_seconds(cur - 1);
      OP_ADD:  st = commit_seconds(cur + opnd);
      OP_SUB:  st = (opnd > cur) ? ST_UNDER : commit_seconds(cur - opnd);
      default: st = ST_OK;
    endcase
    r.days    = acc_days[OUT_DAY_W-1:0];
    r.hours   = acc_hours[HOUR_W-1:0];
    r.minutes = acc_minutes[MIN_W-1:0];
    r.seconds = acc_seconds[SEC_W-1:0];
    r.total   = TOTAL_W'(held_seconds());
    r.status  = st;
    return r;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op,
                                  input logic [OPND_DAY_W-1:0] d,
                                  input logic [HOUR_W-1:0] h,
                                  input logic [MIN_W-1:0] m,
                                  input logic [SEC_W-1:0] s,
                                  input bit typed = 1'b0,
                                  input logic [OUT_DAY_W-1:0] wd = '0,
                                  input logic [HOUR_W-1:0] wh = '0,
                                  input logic [MIN_W-1:0] wm = '0,
                                  input logic [SEC_W-1:0] ws = '0,
                                  input logic [TOTAL_W-1:0] wt = '0,
                                  input status_t wst = ST_OK);
    stim_row_t row;
    row.op           = op;
    row.days         = d;
    row.hours        = h;
    row.minutes      = m;
    row.seconds      = s;
    row.typed        = typed;
    row.want.days    = wd;
    row.want.hours   = wh;
    row.want.minutes = wm;
    row.want.seconds = ws;
    row.want.total   = wt;
    row.want.status  = wst;
    directed_rows.push_back(row);
  endfunction

  // Offer one transaction, hold it until taken, then record what the block must return
  task automatic send_time_op(input logic [OP_W-1:0] op,
                              input logic [OPND_DAY_W-1:0] d,
                              input logic [HOUR_W-1:0] h,
                              input logic [MIN_W-1:0] m,
                              input logic [SEC_W-1:0] s,
                              input bit typed,
                              input time_result_t want);
    time_result_t pred;
    int           gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, s, m, h, d};
    forever begin
      @(posedge clk);
      if (in_taken) break;
    end
    pred = apply_time_op(op, d, h, m, s);
    pending_times.push_back(typed ? want : pred);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sample both handshakes mid-cycle, where every signal is settled
  always @(negedge clk) begin
    time_result_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_times.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transaction with nothing expected: data %h status %0d",
                   $realtime, out_tdata, out_tuser);
      end else begin
        want = pending_times.pop_front();
        if (out_tdata[15:0] !== want.days || out_tdata[20:16] !== want.hours ||
            out_tdata[26:21] !== want.minutes || out_tdata[32:27] !== want.seconds ||
            out_tdata[65:33] !== want.total || out_tuser !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch exp %0d %0d:%0d:%0d tot %0d st %0d",
                     $realtime, want.days, want.hours, want.minutes, want.seconds,
                     want.total, want.status);
            $display("%0t:          got %0d %0d:%0d:%0d tot %0d st %0d",
                     $realtime, out_tdata[15:0], out_tdata[20:16],
                     out_tdata[26:21], out_tdata[32:27], out_tdata[65:33], out_tuser);
          end
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    out_tready = 1'b0;
    hold_seen  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus
  initial begin
    time_result_t    none;
    stim_row_t       row;
    logic [OP_W-1:0] op;
    logic [OPND_DAY_W-1:0] d;
    logic [HOUR_W-1:0] h;
    logic [MIN_W-1:0]  m;
    logic [SEC_W-1:0]  s;
    int pick;
    int phase;
    none           = '{default: '0, status: ST_OK};
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq       = 0;
    acc_days       = 0;
    acc_hours      = 0;
    acc_minutes    = 0;
    acc_seconds    = 0;

    // Directed: reset value, extremes, carries and borrows, both error codes
    add_row(OP_DEC,  16'd0,     5'd0,  6'd0,  6'd0,  1, 0, 0, 0, 0, 0, ST_UNDER);
    add_row(OP_INC,  16'd0,     5'd0,  6'd0,  6'd0,  1, 0, 0, 0, 1, 1, ST_OK);
    add_row(OP_LOAD, 16'hFFFF,  5'd23, 6'd59, 6'd59, 1, 16'hFFFF, 23, 59, 59,
            33'd5662310399, ST_OK);
    add_row(OP_INC,  16'd0,     5'd0,  6'd0,  6'd0,  1, 16'hFFFF, 23, 59, 59,
            33'd5662310399, ST_OVER);
    add_row(OP_ADD,  16'd0,     5'd0,  6'd0,  6'd0);
    add_row(OP_LOAD, 16'hFFFF,  5'd31, 6'd63, 6'd63, 1, 16'hFFFF, 23, 59, 59,
            33'd5662310399, ST_OVER);
    add_row(OP_LOAD, 16'd0,     5'd31, 6'd63, 6'd63);
    add_row(OP_SUB,  16'hFFFF,  5'd23, 6'd59, 6'd59);
    add_row(OP_LOAD, 16'd0,     5'd0,  6'd0,  6'd0,  1, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_SUB,  16'd0,     5'd0,  6'd0,  6'd0,  1, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_SUB,  16'd0,     5'd0,  6'd0,  6'd1,  1, 0, 0, 0, 0, 0, ST_UNDER);
    add_row(OP_SPARE_A, 16'hFFFF, 5'd31, 6'd63, 6'd63, 1, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_LOAD, 16'd0,     5'd0,  6'd59, 6'd59);
    add_row(OP_INC,  16'd0,     5'd0,  6'd0,  6'd0);
    add_row(OP_LOAD, 16'd0,     5'd23, 6'd59, 6'd59);
    add_row(OP_INC,  16'd0,     5'd0,  6'd0,  6'd0,  1, 1, 0, 0, 0, 86400, ST_OK);
    add_row(OP_DEC,  16'd0,     5'd0,  6'd0,  6'd0,  1, 0, 23, 59, 59, 86399, ST_OK);
    add_row(OP_ADD,  16'd0,     5'd23, 6'd59, 6'd59);
    add_row(OP_SUB,  16'd1,     5'd23, 6'd59, 6'd58, 1, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_ADD,  16'hFFFF,  5'd23, 6'd59, 6'd59);
    add_row(OP_ADD,  16'd0,     5'd0,  6'd0,  6'd1);
    add_row(OP_SPARE_B, 16'h5555, 5'd10, 6'd21, 6'd42);
    add_row(OP_SUB,  16'h8000,  5'd16, 6'd32, 6'd32);
    add_row(OP_SPARE_C, 16'hAAAA, 5'd21, 6'd42, 6'd21);
    add_row(OP_DEC,  16'd0,     5'd0,  6'd0,  6'd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_time_op(row.op, row.days, row.hours, row.minutes, row.seconds,
                   row.typed, row.want);
    end

    // Random: mostly legal operands, with some denormal fields and unused ops
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  hold_seq <= hold_seq + 1; end
        1: begin send_idle_pct = 76; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 76; end
        default: begin send_idle_pct = 10; recv_stall_pct <= 10; end
      endcase
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 15)      op = OP_LOAD;
        else if (pick < 35) op = OP_INC;
        else if (pick < 55) op = OP_DEC;
        else if (pick < 75) op = OP_ADD;
        else if (pick < 93) op = OP_SUB;
        else                op = OP_W'($urandom_range(OP_SPARE_C, OP_SPARE_A));

        pick = $urandom_range(9);
        if (pick < 4)      d = OPND_DAY_W'($urandom_range(3));
        else if (pick < 6) d = OPND_DAY_W'($urandom_range(16'hFFFF));
        else if (pick < 8) d = OPND_DAY_W'($urandom_range(16'hFFFF, 16'hFFF8));
        else               d = '0;
        if ($urandom_range(99) < 85) h = HOUR_W'($urandom_range(HOUR_MAX));
        else                         h = HOUR_W'($urandom_range((1 << HOUR_W) - 1));
        if ($urandom_range(99) < 85) m = MIN_W'($urandom_range(MIN_MAX));
        else                         m = MIN_W'($urandom_range((1 << MIN_W) - 1));
        if ($urandom_range(99) < 85) s = SEC_W'($urandom_range(SEC_MAX));
        else                         s = SEC_W'($urandom_range((1 << SEC_W) - 1));

        // Steer some loads to zero and some subtracts to the stored time exactly
        if (op == OP_LOAD && $urandom_range(9) == 0) begin
          d = '0; h = '0; m = '0; s = '0;
        end
        if (op == OP_SUB && $urandom_range(7) == 0) begin
          d = acc_days[OPND_DAY_W-1:0];
          h = acc_hours[HOUR_W-1:0];
          m = acc_minutes[MIN_W-1:0];
          s = acc_seconds[SEC_W-1:0];
        end
        send_time_op(op, d, h, m, s, 1'b0, none);
      end
    end

    // Drain the results still in flight
    in_tvalid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_times.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/dhms_pkg.sv
rtl/dhms_step.sv
rtl/dhms_total.sv
rtl/day_hms_time_accumulator.sv
tb/tb_day_hms_time_accumulator.sv
